// ===== rtl/msm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the sample playback mixer: request codes, controller states,
// field widths and the command and status structs. No dependencies.

package msm_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SADDR_W  = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned WADDR_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PHASE_W  = 20;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned MIX_SHIFT = 3;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_MUTE  = 2'd2,
    REQ_WRITE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic tick_init;
    logic start;
    logic mute;
    logic write;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_chan;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/msm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic memory with one write port and one registered read port.
// No dependencies.

module msm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/msm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Controller of the sample playback mixer: decodes requests, sequences the
// channel scan of a tick and owns the output valid. Depends on msm_pkg.

module msm_ctrl
  import msm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire logic [REQ_W-1:0] req_type_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  input  wire ctrl_sts_t        sts_i,
  output ctrl_cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   accept;
  req_e   req;

  assign req       = req_e'(req_type_i);
  assign accept    = s_valid_i && (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_d = m_valid_q && !m_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (accept) begin
          unique case (req)
            REQ_TICK: begin
              cmd_o.tick_init = 1'b1;
              state_d         = ST_SCAN;
            end
            REQ_START: cmd_o.start = 1'b1;
            REQ_MUTE:  cmd_o.mute  = 1'b1;
            REQ_WRITE: cmd_o.write = 1'b1;
            default:   cmd_o       = '0;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last_chan) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!m_valid_q || m_ready_i))
    else $error("result register loaded while a result is pending");

  a_tick_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req == REQ_TICK) |=> state_q == ST_SCAN)
    else $error("tick did not start a channel scan");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.last_chan) |=> state_q == ST_DRAIN)
    else $error("scan did not stop after the last channel");
`endif

endmodule

`default_nettype wire

// ===== rtl/msm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the sample playback mixer: channel table, sample store,
// accumulator and result register. Depends on msm_pkg and msm_ram.

module msm_datapath
  import msm_pkg::*;
#(
  parameter int unsigned CHANNELS     = 8,
  parameter int unsigned SAMPLE_DEPTH = 65536,
  parameter int unsigned HOLD_SHIFT   = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  output ctrl_sts_t               sts_o,
  input  wire logic [CHAN_W-1:0]  channel_i,
  input  wire logic [SADDR_W-1:0] start_address_i,
  input  wire logic [LEN_W-1:0]   sound_length_i,
  input  wire logic [WADDR_W-1:0] write_address_i,
  input  wire logic [BYTE_W-1:0]  write_byte_i,
  output logic      [LEVEL_W-1:0] pwm_level_o,
  output logic      [MASK_W-1:0]  active_mask_o
);

  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int unsigned LIM_W  = LEN_W + HOLD_SHIFT;
  localparam int unsigned CMP_W  = (LIM_W > PHASE_W) ? LIM_W : PHASE_W;
  localparam int unsigned ASUM_W = PHASE_W + 1;
  localparam int unsigned WA_W   = (ADDR_W > WADDR_W) ? ADDR_W : WADDR_W;
  localparam int unsigned SUM_W  = $clog2(CHANNELS * 255 + 1);
  localparam int unsigned EXT_W  =
    (SUM_W > MIX_SHIFT + LEVEL_W) ? SUM_W : MIX_SHIFT + LEVEL_W;

  logic [CHANNELS-1:0] active_q;
  logic [SADDR_W-1:0]  base_q  [CHANNELS];
  logic [LEN_W-1:0]    len_q   [CHANNELS];
  logic [PHASE_W-1:0]  phase_q [CHANNELS];

  logic [IDX_W-1:0]   idx_q;
  logic               add_q;
  logic [SUM_W-1:0]   sum_q;
  logic [LEVEL_W-1:0] pwm_q;
  logic [MASK_W-1:0]  mask_q;

  logic               sel_active;
  logic [SADDR_W-1:0] sel_base;
  logic [LEN_W-1:0]   sel_len;
  logic [PHASE_W-1:0] sel_phase;
  logic               sel_ended;
  logic [ASUM_W-1:0]  addr_sum;
  logic [ADDR_W-1:0]  rd_addr;
  logic [WA_W-1:0]    wr_addr_ext;
  logic [BYTE_W-1:0]  rd_data;
  logic [MASK_W-1:0]  mask_d;
  logic [EXT_W-1:0]   sum_ext;

  always_comb begin
    sel_active = 1'b0;
    sel_base   = '0;
    sel_len    = '0;
    sel_phase  = '0;
    for (int e = 0; e < CHANNELS; e++) begin
      if (idx_q == IDX_W'(e)) begin
        sel_active = active_q[e];
        sel_base   = base_q[e];
        sel_len    = len_q[e];
        sel_phase  = phase_q[e];
      end
    end
  end

  assign sel_ended   = CMP_W'(sel_phase) >= (CMP_W'(sel_len) << HOLD_SHIFT);
  assign addr_sum    = ASUM_W'(sel_base) + ASUM_W'(sel_phase >> HOLD_SHIFT);
  assign rd_addr     = addr_sum[ADDR_W-1:0];
  assign wr_addr_ext = WA_W'(write_address_i);
  assign sts_o.last_chan = (idx_q == IDX_W'(CHANNELS - 1));

  msm_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(wr_addr_ext[ADDR_W-1:0]),
    .wdata_i(write_byte_i),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      for (int e = 0; e < CHANNELS; e++) begin
        if (cmd_i.mute) begin
          active_q[e] <= 1'b0;
        end else if (cmd_i.start && 32'(channel_i) == e) begin
          active_q[e] <= 1'b1;
        end else if (cmd_i.scan && idx_q == IDX_W'(e) && sel_active && sel_ended) begin
          active_q[e] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < CHANNELS; e++) begin
      if (cmd_i.start && 32'(channel_i) == e) begin
        base_q[e]  <= start_address_i;
        len_q[e]   <= sound_length_i;
        phase_q[e] <= '0;
      end else if (cmd_i.scan && idx_q == IDX_W'(e) && sel_active && !sel_ended) begin
        phase_q[e] <= sel_phase + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      add_q <= 1'b0;
      sum_q <= '0;
    end else begin
      add_q <= cmd_i.scan && sel_active && !sel_ended;
      if (cmd_i.tick_init) begin
        idx_q <= '0;
        sum_q <= '0;
      end else begin
        if (cmd_i.scan && !sts_o.last_chan) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (add_q) begin
          sum_q <= sum_q + SUM_W'(rd_data);
        end
      end
    end
  end

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < CHANNELS) begin : g_used
      assign mask_d[g] = active_q[g];
    end else begin : g_unused
      assign mask_d[g] = 1'b0;
    end
  end

  assign sum_ext = EXT_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pwm_q  <= sum_ext[MIX_SHIFT +: LEVEL_W];
      mask_q <= mask_d;
    end
  end

  assign pwm_level_o   = pwm_q;
  assign active_mask_o = mask_q;

`ifndef SYNTH
  a_add_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_q |-> $past(cmd_i.scan))
    else $error("sample added without a channel scan before it");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_init |=> sum_q == '0)
    else $error("accumulator not cleared at the start of a tick");

  a_mute_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mute |=> active_q == '0)
    else $error("channels still active after mute");
`endif

endmodule

`default_nettype wire

// ===== rtl/multichannel_sample_mixer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the multichannel sample playback mixer: controller and
// datapath joined by command and status structs. Depends on msm_pkg, msm_ctrl and msm_datapath.

// A tick item walks the channel table one channel per cycle, because each
// playing channel needs one read of the single sample store read port; its
// result goes through the scan, drain and finish states to the output register,
// finish waiting while an earlier result is pending; the next item is taken
// once the result is there. Start, mute and sample write items take effect on
// acceptance. The result register lets a new item in while a result still
// waits. SAMPLE_DEPTH must be a power of two. The sample store has no reset;
// channel active bits clear at reset, so no clearing pass is needed.
module multichannel_sample_mixer_core
  import msm_pkg::*;
#(
  parameter int unsigned CHANNELS     = 8,
  parameter int unsigned SAMPLE_DEPTH = 65536,
  parameter int unsigned HOLD_SHIFT   = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // channel[2:0], start_address[18:3], sound_length[35:19],
  // write_address[51:36], write_byte[59:52], zeros above.
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // req_type[1:0].
  input  wire logic [REQ_W-1:0]    s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // pwm_level[7:0], active_mask[15:8].
  output logic      [M_DATA_W-1:0] m_axis_tdata
);

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic [LEVEL_W-1:0] pwm_level;
  logic [MASK_W-1:0]  active_mask;

  msm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .req_type_i(s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  msm_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_DEPTH(SAMPLE_DEPTH),
    .HOLD_SHIFT  (HOLD_SHIFT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .channel_i      (s_axis_tdata[2:0]),
    .start_address_i(s_axis_tdata[18:3]),
    .sound_length_i (s_axis_tdata[35:19]),
    .write_address_i(s_axis_tdata[51:36]),
    .write_byte_i   (s_axis_tdata[59:52]),
    .pwm_level_o    (pwm_level),
    .active_mask_o  (active_mask)
  );

  assign m_axis_tdata = {active_mask, pwm_level};

endmodule

`default_nettype wire
